// File: sv/circular_list_engine_unit_assert.svh
// Assertion macros for the circular list engine.
// No dependencies.
`ifndef CIRCULAR_LIST_ENGINE_UNIT_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_UNIT_ASSERT_SVH
// implication checked every clock, off during reset
`define CLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CLE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/cle_pkg.sv
// Package for the circular list engine: sizes, codes, command/status types.
// No dependencies.
`default_nettype none
package cle_pkg;
    localparam int Capacity = 256;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);

    localparam logic [1:0] KIND_SEARCH = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_CHK,
        S_INS, S_DEL_RD, S_DEL_CHK, S_DEL_UNLINK, S_OUT_RD, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       init_step;   // write free stack entry init_cnt
        logic       load_item;   // latch input item
        logic       walk_start;  // walk counter := 0, walk node := current
        logic       rd_cur;      // read data/link at walk node
        logic       walk_adv;    // walk node := link, counter++
        logic       set_cur;     // current := walk node
        logic       ins_empty;   // self-linked insert
        logic       ins_after;   // insert after walk node
        logic       del_only;    // delete only node
        logic       prev_start;  // prev := walk node, counter := 0
        logic       rd_prev;     // read link of prev, then data of successor
        logic       prev_adv;
        logic       unlink;
        logic       rd_out;      // read current node data
        logic       set_status;
        logic [1:0] status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       init_done;
        logic [1:0] kind;
        logic       empty;
        logic       full;
        logic       one;
        logic       walk_hit;
        logic       walk_end;
        logic       prev_hit;
        logic       prev_end;
    } sts_t;
endpackage
`default_nettype wire

// File: sv/circular_list_engine_unit.sv
// Circular list engine: one search, insert or delete per item, one result each.
// Each item passes dispatch, output read and output; search/insert walk nodes with a read and a check step each.
// Delete then makes a second walk, with a read, a check and an unlink step per node.
// A new item is taken only after the result has been accepted; the single node-store read port sets these steps.
// After reset the free stack is filled, one entry a cycle, and no item is taken until it is full.
// Depends on cle_pkg, cle_controller, cle_datapath.
`default_nettype none
module circular_list_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // kind
    input  wire logic [63:0] s_tdata,   // data_value[31:0], key_value[63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [1:0]       m_tuser,   // status
    output logic [47:0]      m_tdata    // node_total[8:0], current_data[40:9], zero pad
);
    import cle_pkg::*;

    cmd_t            cmd;
    sts_t            sts;
    logic [CntW-1:0] total;
    logic [31:0]     cur_data;

    // sequencer: owns the handshake and walk order
    cle_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // node store, free stack and result registers
    cle_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (s_tuser),
        .in_data     (s_tdata[31:0]),
        .in_key      (s_tdata[63:32]),
        .out_status  (m_tuser),
        .out_total   (total),
        .out_current (cur_data)
    );

    assign m_tdata = {7'd0, cur_data, total};
endmodule
`default_nettype wire

// File: sv/cle_datapath.sv
// Datapath of the circular list engine: node store, free stack, walk registers.
// Depends on cle_pkg.
`default_nettype none
module cle_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cle_pkg::cmd_t         cmd,
    output cle_pkg::sts_t              sts,
    input  wire logic [1:0]            in_kind,
    input  wire logic [31:0]           in_data,
    input  wire logic [31:0]           in_key,
    output logic [1:0]                 out_status,
    output logic [cle_pkg::CntW-1:0]   out_total,
    output logic [31:0]                out_current
);
    import cle_pkg::*;

    logic [31:0]     node_data [Capacity];
    logic [IdxW-1:0] node_link [Capacity];
    logic [IdxW-1:0] free_stack [Capacity];

    logic [CntW-1:0] free_top_reg, list_count_reg, walk_cnt_reg, init_cnt_reg;
    logic [IdxW-1:0] current_reg, walk_reg, prev_reg, victim_reg;
    logic [1:0]      kind_reg, status_reg;
    logic [31:0]     dval_reg, kval_reg, rd_data_reg, cur_data_reg;
    logic [IdxW-1:0] rd_link_reg, free_rd_reg;
    logic            prev_phase_reg;  // 0: link of prev read, 1: successor read

    logic [IdxW-1:0] free_idx;
    logic [31:0]     match_val;
    assign free_idx  = free_top_reg[IdxW-1:0] - IdxW'(1);
    assign match_val = (kind_reg == KIND_INSERT) ? kval_reg : dval_reg;

    // free stack read for the next pop, registered
    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
            free_stack[init_cnt_reg[IdxW-1:0]] <=
                IdxW'(Capacity - 1) - init_cnt_reg[IdxW-1:0];
        else if (cmd.unlink)
            free_stack[free_top_reg[IdxW-1:0]] <= victim_reg;
        else if (cmd.del_only)
            free_stack[free_top_reg[IdxW-1:0]] <= walk_reg;
        free_rd_reg <= free_stack[free_idx];
    end

    // node store: one registered read port; insert after writes two link entries
    always_ff @(posedge clk)
    begin
        if (cmd.ins_empty)
        begin
            node_data[free_rd_reg] <= dval_reg;
            node_link[free_rd_reg] <= free_rd_reg;
        end
        else if (cmd.ins_after)
        begin
            node_data[free_rd_reg] <= dval_reg;
            node_link[free_rd_reg] <= rd_link_reg;
        end
        if (cmd.ins_after)
            node_link[walk_reg] <= free_rd_reg;
        else if (cmd.unlink)
            node_link[prev_reg] <= rd_link_reg;
        if (cmd.rd_cur)
        begin
            rd_data_reg <= node_data[walk_reg];
            rd_link_reg <= node_link[walk_reg];
        end
        else if (cmd.rd_prev)
        begin
            if (!prev_phase_reg)
                rd_link_reg <= node_link[prev_reg];
            else
            begin
                rd_data_reg <= node_data[rd_link_reg];
                rd_link_reg <= node_link[rd_link_reg];
            end
        end
        else if (cmd.rd_out)
            cur_data_reg <= node_data[current_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg   <= CntW'(Capacity);
            list_count_reg <= '0;
            current_reg    <= '0;
            init_cnt_reg   <= '0;
            walk_cnt_reg   <= '0;
            walk_reg       <= '0;
            prev_reg       <= '0;
            victim_reg     <= '0;
            prev_phase_reg <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            if (cmd.init_step)
                init_cnt_reg <= init_cnt_reg + CntW'(1);
            if (cmd.walk_start)
            begin
                walk_reg     <= current_reg;
                walk_cnt_reg <= '0;
            end
            if (cmd.walk_adv)
            begin
                walk_reg     <= rd_link_reg;
                walk_cnt_reg <= walk_cnt_reg + CntW'(1);
            end
            if (cmd.set_cur)
                current_reg <= walk_reg;
            if (cmd.ins_empty)
            begin
                current_reg    <= free_rd_reg;
                list_count_reg <= CntW'(1);
                free_top_reg   <= free_top_reg - CntW'(1);
            end
            if (cmd.ins_after)
            begin
                list_count_reg <= list_count_reg + CntW'(1);
                free_top_reg   <= free_top_reg - CntW'(1);
            end
            if (cmd.del_only)
            begin
                current_reg    <= '0;
                list_count_reg <= '0;
                if (free_top_reg < CntW'(Capacity))
                    free_top_reg <= free_top_reg + CntW'(1);
            end
            if (cmd.prev_start)
            begin
                prev_reg       <= walk_reg;
                walk_cnt_reg   <= '0;
                prev_phase_reg <= 1'b0;
            end
            if (cmd.rd_prev)
            begin
                prev_phase_reg <= ~prev_phase_reg;
                // successor index is the link read in the previous phase
                if (prev_phase_reg)
                    victim_reg <= rd_link_reg;
            end
            if (cmd.prev_adv)
            begin
                prev_reg     <= victim_reg;
                walk_cnt_reg <= walk_cnt_reg + CntW'(1);
            end
            if (cmd.unlink)
            begin
                current_reg    <= rd_link_reg;
                list_count_reg <= list_count_reg - CntW'(1);
                if (free_top_reg < CntW'(Capacity))
                    free_top_reg <= free_top_reg + CntW'(1);
            end
            if (cmd.set_status)
                status_reg <= cmd.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= in_kind;
            dval_reg <= in_data;
            kval_reg <= in_key;
        end
    end

    assign sts.init_done = (init_cnt_reg == CntW'(Capacity));
    assign sts.kind      = kind_reg;
    assign sts.empty     = (list_count_reg == '0);
    assign sts.full      = (free_top_reg == '0);
    assign sts.one       = (list_count_reg == CntW'(1));
    assign sts.walk_hit  = (rd_data_reg == match_val);
    assign sts.walk_end  = (walk_cnt_reg == list_count_reg);
    assign sts.prev_hit  = (rd_data_reg == dval_reg);
    assign sts.prev_end  = (walk_cnt_reg == list_count_reg);

    assign out_status  = status_reg;
    assign out_total   = list_count_reg;
    assign out_current = (list_count_reg == '0) ? 32'd0 : cur_data_reg;
endmodule
`default_nettype wire

// File: sv/cle_controller.sv
// Controller state machine of the circular list engine.
// Depends on cle_pkg and circular_list_engine_unit_assert.svh.
`default_nettype none
`include "circular_list_engine_unit_assert.svh"
module cle_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire cle_pkg::sts_t sts,
    output cle_pkg::cmd_t      cmd
);
    import cle_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                if (sts.init_done)
                    state_next = S_IDLE;
                else
                    cmd.init_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.walk_start = 1'b1;
                cmd.set_status = 1'b1;
                state_next     = S_OUT_RD;
                if (sts.kind == KIND_INSERT)
                begin
                    if (sts.full)
                        cmd.status = ST_FULL;
                    else if (sts.empty)
                    begin
                        cmd.status = ST_OK;
                        state_next = S_INS;
                    end
                    else
                        state_next = S_WALK_RD;
                end
                else if (sts.kind inside {KIND_SEARCH, KIND_DELETE})
                begin
                    if (sts.empty)
                        cmd.status = ST_EMPTY;
                    else
                        state_next = S_WALK_RD;
                end
                else
                    cmd.status = ST_NONE;
            end
            S_WALK_RD:
            begin
                if (sts.walk_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NONE;
                    state_next     = S_OUT_RD;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (sts.walk_hit)
                begin
                    cmd.set_cur    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    if (sts.kind == KIND_INSERT)
                        state_next = S_INS;
                    else if (sts.kind == KIND_DELETE)
                    begin
                        if (sts.one)
                        begin
                            cmd.del_only = 1'b1;
                            state_next   = S_OUT_RD;
                        end
                        else
                        begin
                            cmd.prev_start = 1'b1;
                            state_next     = S_DEL_RD;
                        end
                    end
                    else
                        state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_WALK_RD;
                end
            end
            S_INS:
            begin
                if (sts.empty)
                    cmd.ins_empty = 1'b1;
                else
                    cmd.ins_after = 1'b1;
                state_next = S_OUT_RD;
            end
            S_DEL_RD:
            begin
                if (sts.prev_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NONE;
                    state_next     = S_OUT_RD;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_DEL_CHK;
                end
            end
            S_DEL_CHK:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_DEL_UNLINK;
            end
            S_DEL_UNLINK:
            begin
                if (sts.prev_hit)
                begin
                    cmd.unlink = 1'b1;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.prev_adv = 1'b1;
                    state_next   = S_DEL_RD;
                end
            end
            S_OUT_RD:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_INIT;
        endcase
    end

    `CLE_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "accept while result pending")
    `CLE_ASSERT_NXT(a_accept_dispatch, in_valid && in_ready, state_reg == S_DISPATCH,
        "accepted item not dispatched")
    `CLE_ASSERT_IMP(a_one_write, cmd.ins_after, !cmd.unlink && !cmd.del_only,
        "two store writes in one cycle")
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for circular_list_engine_unit: random and directed list operations.
// Holds its own list predictor and checks every result item. Depends on cle_pkg.
`default_nettype none
module tb_top;
    import cle_pkg::*;

    localparam int NODES      = 256;
    localparam int CYCLE_CAP  = 8000000;
    localparam int RAND_ITEMS = 170;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] dval;
        logic [31:0] kval;
    } op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  total;
        logic [31:0] cur_val;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // kind
    logic [63:0] s_tdata;   // data_value[31:0], key_value[63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;   // status
    logic [47:0] m_tdata;   // node_total[8:0], current_data[40:9], zero pad

    circular_list_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // list shadow state
    logic [31:0] ring_val  [NODES];
    int          ring_next [NODES];
    int          spare     [NODES];
    int          spare_top;
    int          cur_node;
    int          node_cnt;

    op_t    pending_ops[$];
    reply_t replies_due[$];
    int     errors;
    bit     idle_on;
    bit     gen_done;
    int     cycles;

    function automatic bit seek_value(logic [31:0] v);
        for (int i = 0; i < node_cnt; i++)
        begin
            if (ring_val[cur_node] == v)
                return 1'b1;
            cur_node = ring_next[cur_node];
        end
        return 1'b0;
    endfunction

    function automatic reply_t apply_op(op_t op);
        reply_t r;
        logic [1:0] st;
        int n;
        int prev;
        int victim;
        int i;
        st = ST_NONE;
        if (op.kind == KIND_SEARCH)
        begin
            if (node_cnt == 0)
                st = ST_EMPTY;
            else
                st = seek_value(op.dval) ? ST_OK : ST_NONE;
        end
        else if (op.kind == KIND_INSERT)
        begin
            if (spare_top == 0)
                st = ST_FULL;
            else if (node_cnt == 0)
            begin
                spare_top--;
                n = spare[spare_top];
                ring_val[n]  = op.dval;
                ring_next[n] = n;
                cur_node = n;
                node_cnt = 1;
                st = ST_OK;
            end
            else if (seek_value(op.kval))
            begin
                spare_top--;
                n = spare[spare_top];
                ring_val[n]  = op.dval;
                ring_next[n] = ring_next[cur_node];
                ring_next[cur_node] = n;
                node_cnt++;
                st = ST_OK;
            end
        end
        else if (op.kind == KIND_DELETE)
        begin
            if (node_cnt == 0)
                st = ST_EMPTY;
            else if (seek_value(op.dval))
            begin
                if (node_cnt == 1)
                begin
                    if (spare_top < NODES)
                    begin
                        spare[spare_top] = cur_node;
                        spare_top++;
                    end
                    cur_node = 0;
                    node_cnt = 0;
                    st = ST_OK;
                end
                else
                begin
                    // second walk: find the node whose successor holds the value
                    prev = cur_node;
                    for (i = 0; i < node_cnt; i++)
                    begin
                        if (ring_val[ring_next[prev]] == op.dval)
                            break;
                        prev = ring_next[prev];
                    end
                    if (i < node_cnt)
                    begin
                        victim = ring_next[prev];
                        ring_next[prev] = ring_next[victim];
                        cur_node = ring_next[victim];
                        if (spare_top < NODES)
                        begin
                            spare[spare_top] = victim;
                            spare_top++;
                        end
                        node_cnt--;
                        st = ST_OK;
                    end
                end
            end
        end
        r.status  = st;
        r.total   = node_cnt[8:0];
        r.cur_val = (node_cnt != 0) ? ring_val[cur_node] : 32'd0;
        return r;
    endfunction

    // item driver: predicts on acceptance, then loads the next pending item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                replies_due.push_back(apply_op({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() > 0 && !(idle_on && $urandom_range(99) < 14))
                begin
                    op_t op;
                    op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= op.kind;
                    s_tdata  <= {op.kval, op.dval};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= !(idle_on && $urandom_range(99) < 14);
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d total=%0d data=%h",
                             $time, m_tuser, m_tdata[8:0], m_tdata[40:9]);
                    errors++;
                end
                else
                begin
                    reply_t want;
                    want = replies_due.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[8:0] !== want.total)
                    begin
                        $display("%0t: node_total expected %0d actual %0d",
                                 $time, want.total, m_tdata[8:0]);
                        errors++;
                    end
                    if (m_tdata[40:9] !== want.cur_val)
                    begin
                        $display("%0t: current_data expected %h actual %h",
                                 $time, want.cur_val, m_tdata[40:9]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // keeps the generator only a couple of items ahead so it can read node_cnt
    task automatic send(logic [1:0] kind, logic [31:0] dv, logic [31:0] kv);
        op_t op;
        while (pending_ops.size() >= 2)
            @(posedge clk);
        op.kind = kind;
        op.dval = dv;
        op.kval = kv;
        pending_ops.push_back(op);
    endtask

    logic [31:0] vals[8];

    initial
    begin
        int r;
        logic [1:0] k;
        errors    = 0;
        cycles    = 0;
        idle_on   = 1'b1;
        gen_done  = 1'b0;
        spare_top = NODES;
        cur_node  = 0;
        node_cnt  = 0;
        for (int i = 0; i < NODES; i++)
        begin
            spare[i]     = NODES - 1 - i;
            ring_val[i]  = '0;
            ring_next[i] = 0;
        end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, extremes, misses, only-node delete
        send(KIND_SEARCH, 32'h0000_0001, 32'h0);
        send(KIND_DELETE, 32'h0000_0001, 32'h0);
        send(KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
        send(KIND_SEARCH, 32'h8000_0000, 32'h0);
        send(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0);
        send(KIND_DELETE, 32'h7FFF_FFFF, 32'h0);
        send(KIND_DELETE, 32'h8000_0000, 32'h0);
        send(KIND_INSERT, 32'h7FFF_FFFF, 32'h0);
        send(KIND_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send(KIND_INSERT, 32'h1234_5678, 32'h8000_0000);
        send(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0);
        send(KIND_DELETE, 32'h0000_0000, 32'h0);
        send(KIND_DELETE, 32'hFFFF_FFFF, 32'h0);
        send(KIND_DELETE, 32'h7FFF_FFFF, 32'h0);

        // fill to capacity with duplicates so each walk ends at once
        for (int i = 0; i < NODES; i++)
            send(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        send(KIND_INSERT, 32'h5555_5555, 32'h0000_0000);  // store full
        send(KIND_SEARCH, 32'hAAAA_AAAA, 32'h0);          // full-ring miss
        for (int i = 0; i < NODES + 1; i++)
            send(KIND_DELETE, 32'h0000_0000, 32'h0);

        // random part: small value pool so searches and keys mostly hit
        vals[0] = 32'h8000_0000;
        vals[1] = 32'h7FFF_FFFF;
        vals[2] = 32'hFFFF_FFFF;
        vals[3] = 32'h0000_0000;
        for (int i = 4; i < 8; i++)
            vals[i] = $urandom;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            idle_on = !(n >= 60 && n < 120);
            if ($urandom_range(19) == 0)
                vals[$urandom_range(4, 7)] = $urandom;
            r = $urandom_range(99);
            if (node_cnt > 40)
                k = (r < 60) ? KIND_DELETE : ((r < 80) ? KIND_SEARCH : KIND_INSERT);
            else
                k = (r < 30) ? KIND_SEARCH : ((r < 70) ? KIND_INSERT : KIND_DELETE);
            if ($urandom_range(9) == 0)
                send(k, $urandom, $urandom);  // noise, mostly misses
            else
                send(k, vals[$urandom_range(7)], vals[$urandom_range(7)]);
        end

        while (pending_ops.size() > 0 || s_tvalid)
            @(posedge clk);
        while (replies_due.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
